// ----- hw/rtl/incremental_pi_controller_defines.svh -----
// assertion macros shared by the controller rtl
`ifndef INCREMENTAL_PI_CONTROLLER_DEFINES_SVH
`define INCREMENTAL_PI_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define IPIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off while rst_n is low
`define IPIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IPIC_ASSERT_IMP(lbl, ante, cons, msg)
`define IPIC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/ipic_pkg.sv -----
package ipic_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_DIV,
    ST_DCLAMP,
    ST_OCLAMP,
    ST_DONE
  } state_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN   = 3'd0,
    CFG_KI_GAIN   = 3'd1,
    CFG_OUT_MIN   = 3'd2,
    CFG_OUT_MAX   = 3'd3,
    CFG_DELTA_MIN = 3'd4,
    CFG_DELTA_MAX = 3'd5
  } cfg_idx_t;

  // sample period 5 ms as an exact division by 200
  localparam int REM_W = 8;
  localparam logic [REM_W-1:0] DIVISOR = 8'd200;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- hw/rtl/ipic_mac.sv -----
`include "incremental_pi_controller_defines.svh"

// serial-parallel signed multiply-accumulate: prod = a*x + b*y
// one bit of x and y per cycle, lsb first, msb carries negative weight
module ipic_mac #(
  parameter int AW = 40,
  parameter int BW = 32,
  parameter int N  = 33
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [AW-1:0]     a_in,
  input  logic signed [BW-1:0]     b_in,
  input  logic        [N-1:0]      x_in,
  input  logic        [N-1:0]      y_in,
  output ipic_pkg::unit_stat_t     stat,
  output logic signed [AW+2+N-1:0] prod
);

  localparam int PW = AW + 2;
  localparam int CW = $clog2(N + 1);

  logic signed [AW-1:0] a_r;
  logic signed [BW-1:0] b_r;
  logic [N-1:0]         x_r, x_nxt;
  logic [N-1:0]         y_r, y_nxt;
  logic signed [PW-1:0] hi_r, hi_nxt;
  logic [N-1:0]         lo_r, lo_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic signed [PW-1:0] pp;
  logic signed [PW-1:0] sum;
  logic                 last;

  // partial product of the current bit pair
  always_comb begin
    pp = '0;
    if (x_r[0]) begin
      pp = pp + PW'(a_r);
    end
    if (y_r[0]) begin
      pp = pp + PW'(b_r);
    end
  end

  // accumulate, subtract on the sign bit, then shift one bit down
  always_comb begin
    last     = (cnt_r == CW'(1));
    sum      = last ? (hi_r - pp) : (hi_r + pp);
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt   = '0;
      lo_nxt   = '0;
      x_nxt    = x_in;
      y_nxt    = y_in;
      cnt_nxt  = CW'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt   = {sum[PW-1], sum[PW-1:1]};
      lo_nxt   = {sum[0], lo_r[N-1:1]};
      x_nxt    = {1'b0, x_r[N-1:1]};
      y_nxt    = {1'b0, y_r[N-1:1]};
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = !last;
      done_nxt = last;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
    end
  end

  // control registers; the shift and accumulator registers follow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = {hi_r, lo_r};

  `IPIC_ASSERT_IMP(a_mac_cnt_live, busy_r, cnt_r != '0, "mac busy with no bits left")
  `IPIC_ASSERT_NXT(a_mac_done_ends, done_r, !done_r || start, "mac done held twice")

endmodule

// ----- hw/rtl/ipic_div200.sv -----
`include "incremental_pi_controller_defines.svh"

// floor division of a signed value by 200, one quotient bit per cycle, msb first
// negative values divide the complement and complement the quotient
module ipic_div200 #(
  parameter int DV = 59
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DV-1:0] dividend,
  output ipic_pkg::unit_stat_t stat,
  output logic signed [DV-1:0] quot
);

  localparam int CW = $clog2(DV + 1);
  localparam int RW = ipic_pkg::REM_W;

  logic [DV-1:0] num_r, num_nxt;
  logic [DV-1:0] q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          fits;
  logic          last;

  // one restoring step
  always_comb begin
    trial = {rem_r, num_r[DV-1]};
    diff  = trial - {1'b0, ipic_pkg::DIVISOR};
    fits  = (trial >= {1'b0, ipic_pkg::DIVISOR});
    last  = (cnt_r == CW'(1));
  end

  always_comb begin
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      neg_nxt  = dividend[DV-1];
      num_nxt  = dividend ^ {DV{dividend[DV-1]}};
      q_nxt    = '0;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DV);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt  = {num_r[DV-2:0], 1'b0};
      q_nxt    = {q_r[DV-2:0], fits};
      rem_nxt  = fits ? diff[RW-1:0] : trial[RW-1:0];
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = !last;
      done_nxt = last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = neg_r ? ~q_r : q_r;

  `IPIC_ASSERT_IMP(a_div_rem_bound, 1'b1, rem_r < ipic_pkg::DIVISOR, "remainder reached 200")
  `IPIC_ASSERT_IMP(a_div_cnt_live, busy_r, cnt_r != '0, "divider busy with no bits left")

endmodule

// ----- hw/rtl/incremental_pi_controller.sv -----
// Velocity-form PI controller in signed fixed point (FRAC_BITS fraction bits). A control
// sample passes through a setup state, the bit-serial multiply-accumulate that forms
// 200*kp*(e - e_prev) + ki*e, the bit-serial divide by 200, and the increment clamp,
// output clamp and hand-off states. A clear item goes from idle straight to the hand-off.
// The block works on one item at a time; it takes the next item as soon as the result is
// parked in the output register, even while that result waits.
// Configuration writes are always taken and must be issued only while the block is idle.
`include "incremental_pi_controller_defines.svh"

module incremental_pi_controller #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic signed [DATA_WIDTH-1:0]     in_measured,
  input  logic signed [DATA_WIDTH-1:0]     in_target,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [DATA_WIDTH-1:0]     out_drive,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ipic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic signed [DATA_WIDTH-1:0]     cfg_data
);

  localparam int W   = DATA_WIDTH;
  localparam int AW  = W + 8;
  localparam int N   = W + 1;
  localparam int PRW = AW + 2 + N;
  localparam int DV  = PRW - FRAC_BITS;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  ipic_pkg::state_t state_r, state_nxt;

  logic signed [W-1:0] kp_gain_r, ki_gain_r;
  logic signed [W-1:0] out_min_r, out_max_r, delta_min_r, delta_max_r;
  logic signed [W-1:0] prev_error_r, prev_output_r;
  logic signed [W-1:0] err_r, delta_r, drive_res_r, out_drive_r;
  logic signed [W-1:0] delta_nxt, drive_res_nxt, err_nxt;
  logic                clr_r;
  logic                out_valid_r;

  logic                 accept;
  logic                 mac_start, div_start, out_load;
  ipic_pkg::unit_stat_t mac_stat, div_stat;

  logic signed [W:0]    err_diff;
  logic signed [AW-1:0] kp_ext, mac_a;
  logic        [N-1:0]  mac_x, mac_y;
  logic signed [PRW-1:0] mac_prod;
  logic signed [DV-1:0]  div_quot;

  logic [DV-W-1:0]     q_upper;
  logic                q_ovf_pos, q_ovf_neg;
  logic signed [W-1:0] q_low;
  logic signed [W:0]   out_sum;
  logic signed [W:0]   out_max_ext, out_min_ext;

  logic st_mac, st_oclamp, st_done;
  logic dlim_ord, olim_ord, delta_ok, drive_ok, hist_zero;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipic_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_kind ? ipic_pkg::ST_DONE : ipic_pkg::ST_SETUP;
        end
      end
      ipic_pkg::ST_SETUP: begin
        state_nxt = ipic_pkg::ST_MAC;
      end
      ipic_pkg::ST_MAC: begin
        if (mac_stat.done) begin
          state_nxt = ipic_pkg::ST_DIV;
        end
      end
      ipic_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ipic_pkg::ST_DCLAMP;
        end
      end
      ipic_pkg::ST_DCLAMP: begin
        state_nxt = ipic_pkg::ST_OCLAMP;
      end
      ipic_pkg::ST_OCLAMP: begin
        state_nxt = ipic_pkg::ST_DONE;
      end
      ipic_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ipic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ipic_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mac_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ipic_pkg::ST_IDLE:  in_ready  = 1'b1;
      ipic_pkg::ST_SETUP: mac_start = 1'b1;
      ipic_pkg::ST_MAC:   div_start = mac_stat.done;
      ipic_pkg::ST_DONE:  out_load  = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipic_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_gain_r   <= '0;
      ki_gain_r   <= '0;
      out_min_r   <= SMIN;
      out_max_r   <= SMAX;
      delta_min_r <= SMIN;
      delta_max_r <= SMAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ipic_pkg::CFG_KP_GAIN:   kp_gain_r   <= cfg_data;
        ipic_pkg::CFG_KI_GAIN:   ki_gain_r   <= cfg_data;
        ipic_pkg::CFG_OUT_MIN:   out_min_r   <= cfg_data;
        ipic_pkg::CFG_OUT_MAX:   out_max_r   <= cfg_data;
        ipic_pkg::CFG_DELTA_MIN: delta_min_r <= cfg_data;
        ipic_pkg::CFG_DELTA_MAX: delta_max_r <= cfg_data;
        default: begin
          kp_gain_r <= kp_gain_r;
        end
      endcase
    end
  end

  // saturated error at transfer, zero for a clear item
  always_comb begin
    err_diff = {in_target[W-1], in_target} - {in_measured[W-1], in_measured};
    if (in_kind) begin
      err_nxt = '0;
    end else if (err_diff[W] != err_diff[W-1]) begin
      err_nxt = err_diff[W] ? SMIN : SMAX;
    end else begin
      err_nxt = err_diff[W-1:0];
    end
  end

  // mac operands: 200*kp against the error step, ki against the error
  always_comb begin
    kp_ext = AW'(kp_gain_r);
    mac_a  = (kp_ext <<< 7) + (kp_ext <<< 6) + (kp_ext <<< 3);
    mac_x  = {err_r[W-1], err_r} - {prev_error_r[W-1], prev_error_r};
    mac_y  = {err_r[W-1], err_r};
  end

  ipic_mac #(
    .AW (AW),
    .BW (W),
    .N  (N)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a_in  (mac_a),
    .b_in  (ki_gain_r),
    .x_in  (mac_x),
    .y_in  (mac_y),
    .stat  (mac_stat),
    .prod  (mac_prod)
  );

  // fraction bits drop as a floor shift ahead of the divide
  ipic_div200 #(
    .DV (DV)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mac_prod[PRW-1:FRAC_BITS]),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  // increment clamp, upper limit tested first
  always_comb begin
    q_upper   = div_quot[DV-2:W-1];
    q_ovf_pos = !div_quot[DV-1] && (|q_upper);
    q_ovf_neg = div_quot[DV-1] && !(&q_upper);
    q_low     = div_quot[W-1:0];
    if (q_ovf_pos) begin
      delta_nxt = delta_max_r;
    end else if (q_ovf_neg) begin
      delta_nxt = delta_min_r;
    end else if (q_low > delta_max_r) begin
      delta_nxt = delta_max_r;
    end else if (q_low < delta_min_r) begin
      delta_nxt = delta_min_r;
    end else begin
      delta_nxt = q_low;
    end
  end

  // output clamp, upper limit tested first, signed compare on widened values
  always_comb begin
    out_sum     = {prev_output_r[W-1], prev_output_r} + {delta_r[W-1], delta_r};
    out_max_ext = {out_max_r[W-1], out_max_r};
    out_min_ext = {out_min_r[W-1], out_min_r};
    if (out_sum > out_max_ext) begin
      drive_res_nxt = out_max_r;
    end else if (out_sum < out_min_ext) begin
      drive_res_nxt = out_min_r;
    end else begin
      drive_res_nxt = out_sum[W-1:0];
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      err_r       <= err_nxt;
      clr_r       <= in_kind;
      drive_res_r <= '0;
    end
    if (state_r == ipic_pkg::ST_DCLAMP) begin
      delta_r <= delta_nxt;
    end
    if (state_r == ipic_pkg::ST_OCLAMP) begin
      drive_res_r <= drive_res_nxt;
    end
    if (out_load) begin
      out_drive_r <= drive_res_r;
    end
  end

  // controller history and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r  <= '0;
      prev_output_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_load) begin
        prev_error_r  <= err_r;
        prev_output_r <= drive_res_r;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // terms for the checks below
  always_comb begin
    st_mac    = (state_r == ipic_pkg::ST_MAC);
    st_oclamp = (state_r == ipic_pkg::ST_OCLAMP);
    st_done   = (state_r == ipic_pkg::ST_DONE);
    dlim_ord  = (delta_min_r <= delta_max_r);
    olim_ord  = (out_min_r <= out_max_r);
    delta_ok  = (delta_r >= delta_min_r) && (delta_r <= delta_max_r);
    drive_ok  = (drive_res_r >= out_min_r) && (drive_res_r <= out_max_r);
    hist_zero = (prev_output_r == '0) && (prev_error_r == '0);
  end

  `IPIC_ASSERT_IMP(a_units_exclusive, 1'b1, !(mac_stat.busy && div_stat.busy), "units overlap")
  `IPIC_ASSERT_IMP(a_mac_done_in_mac, mac_stat.done, st_mac, "mac done outside mac state")
  `IPIC_ASSERT_IMP(a_delta_in_limits, st_oclamp && dlim_ord, delta_ok, "increment off limits")
  `IPIC_ASSERT_IMP(a_drive_in_limits, st_done && !clr_r && olim_ord, drive_ok, "output off limits")
  `IPIC_ASSERT_NXT(a_clear_zeroes, out_load && clr_r, hist_zero, "clear left history")

endmodule
